/* src/relr_pkg.sv */
// ----------------------------------------------------------------------------
// relr_pkg
// Shared types for the relocation decoder: controller commands and
// datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package relr_pkg;

    // Size of one relocated word in bytes
    localparam int unsigned WORD_BYTES = 8;

    typedef struct packed {
        logic accept;   // take the input beat and load the scan registers
        logic step;     // advance the scan by one bitmap position
        logic emit;     // load the current address into the output register
    } relr_cmd_t;

    typedef struct packed {
        logic cur_bit;    // bitmap position under the scan is set
        logic rest_zero;  // no set bits above the current position
        logic new_empty;  // incoming beat would yield no address
        logic out_free;   // output register can take a new address
    } relr_status_t;

endpackage

`default_nettype wire

/* src/relr_ctrl.sv */
// ----------------------------------------------------------------------------
// relr_ctrl
// Controller: takes one input beat at a time and walks the scan until the
// highest set bitmap position has been handled.
// ----------------------------------------------------------------------------
`default_nettype none

module relr_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire relr_pkg::relr_status_t status,
    output relr_pkg::relr_cmd_t        cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.accept = s_valid && (state_reg == ST_IDLE);
        // stall on a set bit while the output register is still full
        cmd.step   = (state_reg == ST_SCAN) && (!status.cur_bit || status.out_free);
        cmd.emit   = (state_reg == ST_SCAN) && status.cur_bit && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && !status.new_empty) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmd.step && status.rest_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_empty_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.new_empty) |=> s_ready)
        else $error("empty bitmap left the controller busy");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.rest_zero) |=> s_ready)
        else $error("scan did not finish after the last set bit");

    a_stall_holds_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) && status.cur_bit && !status.out_free)
        |=> ((state_reg == ST_SCAN) && status.cur_bit))
        else $error("pending address dropped during output stall");
`endif

endmodule

`default_nettype wire

/* src/relr_datapath.sv */
// ----------------------------------------------------------------------------
// relr_datapath
// Datapath: load base, cursor, bitmap shift register, running address and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module relr_datapath #(
    parameter int unsigned BITMAP_BITS = 63
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [63:0]          cfg_wdata,
    input  wire logic [63:0]          s_entry,
    input  wire logic                 s_final_entry,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [63:0]               m_patch_address,
    output logic                      m_last_of_run,
    input  wire relr_pkg::relr_cmd_t  cmd,
    output relr_pkg::relr_status_t    status
);

    localparam logic [63:0] WORD_STEP   = 64'(relr_pkg::WORD_BYTES);
    localparam logic [63:0] BITMAP_SPAN = 64'(relr_pkg::WORD_BYTES * BITMAP_BITS);

    logic [63:0]            load_base_reg;
    logic [63:0]            cursor_reg;
    logic [63:0]            cursor_next;
    logic [BITMAP_BITS-1:0] bits_reg;
    logic [BITMAP_BITS-1:0] bits_next;
    logic [63:0]            addr_reg;
    logic [63:0]            addr_next;
    logic                   out_valid_reg;
    logic [63:0]            out_addr_reg;
    logic                   out_last_reg;
    logic                   is_bitmap;

    assign is_bitmap = s_entry[0];

    always_comb begin
        status.cur_bit   = bits_reg[0];
        status.rest_zero = (bits_reg[BITMAP_BITS-1:1] == '0);
        status.new_empty = is_bitmap && (s_entry[BITMAP_BITS:1] == '0);
        status.out_free  = !out_valid_reg || m_ready;
    end

    always_comb begin
        cursor_next = cursor_reg;
        bits_next   = bits_reg;
        addr_next   = addr_reg;
        if (cmd.accept) begin
            if (is_bitmap) begin
                bits_next   = s_entry[BITMAP_BITS:1];
                addr_next   = load_base_reg + cursor_reg;
                cursor_next = cursor_reg + BITMAP_SPAN;
            end else begin
                // offset word: a one-position scan at the offset itself
                bits_next   = BITMAP_BITS'(1);
                addr_next   = load_base_reg + s_entry;
                cursor_next = s_entry + WORD_STEP;
            end
            if (s_final_entry) begin
                cursor_next = '0;
            end
        end else if (cmd.step) begin
            bits_next = {1'b0, bits_reg[BITMAP_BITS-1:1]};
            addr_next = addr_reg + WORD_STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_base_reg <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                load_base_reg <= cfg_wdata;
            end
            cursor_reg <= cursor_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bits_reg <= bits_next;
        addr_reg <= addr_next;
        if (cmd.emit) begin
            out_addr_reg <= addr_reg;
            out_last_reg <= status.rest_zero;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_patch_address = out_addr_reg;
    assign m_last_of_run   = out_last_reg;

endmodule

`default_nettype wire

/* src/relr_relocation_decoder.sv */
// Output path: an offset beat's address goes into the running address register,
// then into the output register once that register can take a new address.
// Throughput: a new beat is taken only after the scan of the last one ends;
// the scan moves one bitmap position per cycle up to the highest set bit,
// stalling on a set bit while the output register is still full.
// Reset: synchronous, active low; clears load base, cursor, state and m_valid.
// ----------------------------------------------------------------------------
// relr_relocation_decoder
// Decodes packed relative-relocation words into the addresses of the words
// that need the load base added.
// ----------------------------------------------------------------------------
`default_nettype none

module relr_relocation_decoder #(
    parameter int unsigned BITMAP_BITS = 63
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_entry,
    input  wire logic        s_final_entry,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_patch_address,
    output logic             m_last_of_run
);

    relr_pkg::relr_cmd_t    cmd;
    relr_pkg::relr_status_t status;

    relr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    relr_datapath #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_entry         (s_entry),
        .s_final_entry   (s_final_entry),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_patch_address (m_patch_address),
        .m_last_of_run   (m_last_of_run),
        .cmd             (cmd),
        .status          (status)
    );

endmodule

`default_nettype wire
